>>> src/crc_framed_packet_builder_unit_defines.svh
// Assertion macros shared by the framer modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef CRC_FRAMED_PACKET_BUILDER_UNIT_DEFINES_SVH
`define CRC_FRAMED_PACKET_BUILDER_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define CRCFB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define CRCFB_NEVER(name, cond, msg) \
  `CRCFB_ASSERT(name, !(cond), msg)

`endif

>>> src/crcfb_pkg.sv
// Shared constants and types of the byte-stuffed CRC framer.
// No dependencies.
package crcfb_pkg;

  localparam logic [7:0]  FLAG_BYTE     = 8'h7E;
  localparam logic [7:0]  ESC_BYTE      = 8'h7D;
  localparam logic [7:0]  ESC_FLAG      = 8'h5E;
  localparam logic [7:0]  ESC_ESC       = 8'h5D;
  localparam logic [7:0]  HDR_BYTE      = 8'h21;
  localparam logic [15:0] CRC_POLY      = 16'h8408;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [2:0]  MAX_SIZE_CODE = 3'd4;
  localparam int          LEFT_W        = 6;

  // One classified item as it travels from the front end to the sequencer.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [15:0] port_address;
    logic [2:0]  size_code;
    logic        open;   // first byte of a frame: send flag and header first
    logic        last;   // last byte of a frame: send CRC and closing flag after
  } crcfb_item_t;

endpackage

>>> src/crcfb_if.sv
// Valid/ready channel interfaces for payload input and line output.
// Depends on nothing.
interface crcfb_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [15:0] port_address;
  logic [2:0]  size_code;

  modport source (output valid, output payload_byte, output port_address,
                  output size_code, input ready);
  modport sink (input valid, input payload_byte, input port_address,
                input size_code, output ready);
endinterface

interface crcfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, output line_byte, output run_last,
                  output frame_end, input ready);
  modport sink (input valid, input line_byte, input run_last,
                input frame_end, output ready);
endinterface

>>> src/crc_framed_packet_builder_unit.sv
// With the queue empty and the sequencer idle, an accepted beat is written into the queue,
// loaded by the sequencer and then registered before its first line byte is shown.
// The sequencer sends one line byte per cycle while the output is ready. A frame adds five
// to seven header and three to five trailer bytes, a payload beat one, two if escaped.
// Input beats are taken every cycle while the item queue (QUEUE_DEPTH entries) has room.
// Reset clears frame counter, queue, sequencer and output valid, and presets the CRC.
module crc_framed_packet_builder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  crcfb_in_if.sink     in_ch,
  crcfb_out_if.source  out_ch
);
  import crcfb_pkg::*;

  crcfb_item_t push_item;
  crcfb_item_t q_item;
  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        pop;

  // Front end classifies beats and tracks frame length.
  crcfb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // Queue decouples the two sides.
  crcfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_item  (q_item)
  );

  // Back end builds the framed, escaped byte stream.
  crcfb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

>>> src/crcfb_front.sv
// Front end: accepts payload beats, tracks the frame length and tags each item.
// Depends on crcfb_pkg and crcfb_in_if.
module crcfb_front (
  input  logic                 clk,
  input  logic                 rst_n,
  crcfb_in_if.sink             in_ch,
  input  logic                 q_full,
  output logic                 push,
  output crcfb_pkg::crcfb_item_t push_item
);
  import crcfb_pkg::*;

  logic [LEFT_W-1:0] bytes_left_r, bytes_left_nxt;
  logic              accept;
  logic              frame_idle;
  logic              bad_code;
  logic [LEFT_W-1:0] frame_len;
  logic [LEFT_W-1:0] left_after;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign frame_idle  = (bytes_left_r == '0);
  assign bad_code    = in_ch.size_code > MAX_SIZE_CODE;

  // Frame length is two bytes shifted left by the size code.
  assign frame_len  = LEFT_W'(2) << in_ch.size_code;
  assign left_after = (frame_idle ? frame_len : bytes_left_r) - LEFT_W'(1);

  // Classify the beat; a first beat with a bad size code is dropped.
  always_comb begin
    push_item.payload_byte = in_ch.payload_byte;
    push_item.port_address = in_ch.port_address;
    push_item.size_code    = in_ch.size_code;
    push_item.open         = frame_idle;
    push_item.last         = (left_after == '0);
    push                   = accept && !(frame_idle && bad_code);
    bytes_left_nxt         = push ? left_after : bytes_left_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

>>> src/crcfb_queue.sv
// Short queue of classified items between the front end and the sequencer.
// Depends on crcfb_pkg and the assertion macro header.
`include "crc_framed_packet_builder_unit_defines.svh"

module crcfb_queue #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  crcfb_pkg::crcfb_item_t push_item,
  output logic                   full,
  input  logic                   pop,
  output logic                   q_valid,
  output crcfb_pkg::crcfb_item_t pop_item
);
  import crcfb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  crcfb_item_t      slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign q_valid  = (count_r != '0);
  assign pop_item = slots_r[rd_ptr_r];

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  `CRCFB_NEVER(a_no_push_when_full, push && full, "queue written while full")
  `CRCFB_NEVER(a_no_pop_when_empty, pop && !q_valid, "queue read while empty")
  `CRCFB_ASSERT(a_count_bound, (count_r <= CNT_W'(DEPTH)), "queue count overflow")

endmodule

>>> src/crcfb_back.sv
// Back end: walks each frame through flag, header, payload, CRC and closing flag,
// escaping bytes and keeping the running CRC. Depends on crcfb_pkg and crcfb_out_if.
`include "crc_framed_packet_builder_unit_defines.svh"

module crcfb_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  crcfb_pkg::crcfb_item_t q_item,
  output logic                   pop,
  crcfb_out_if.source            out_ch
);
  import crcfb_pkg::*;

  localparam logic [3:0] PH_FLAG = 4'd0;
  localparam logic [3:0] PH_HDR  = 4'd1;
  localparam logic [3:0] PH_CODE = 4'd2;
  localparam logic [3:0] PH_PHI  = 4'd3;
  localparam logic [3:0] PH_PLO  = 4'd4;
  localparam logic [3:0] PH_DATA = 4'd5;
  localparam logic [3:0] PH_CRCL = 4'd6;
  localparam logic [3:0] PH_CRCH = 4'd7;
  localparam logic [3:0] PH_END  = 4'd8;

  // One CRC-16/X25 byte update, LSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  crcfb_item_t item_r, item_nxt;
  logic        busy_r, busy_nxt;
  logic [3:0]  phase_r, phase_nxt;
  logic        esc_pend_r, esc_pend_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_end_r, out_end_nxt;

  logic        adv;
  logic        emit;
  logic [7:0]  raw;
  logic        escapable;
  logic        feeds_crc;
  logic        need_esc;
  logic        complete;
  logic        finishing;
  logic [3:0]  next_phase;

  assign adv  = !out_valid_r || out_ch.ready;
  assign emit = busy_r && adv;

  // Raw byte of the current step and whether it is escaped and covered by the CRC.
  always_comb begin
    raw       = FLAG_BYTE;
    escapable = 1'b1;
    feeds_crc = 1'b1;
    unique case (phase_r)
      PH_FLAG: begin
        raw       = FLAG_BYTE;
        escapable = 1'b0;
        feeds_crc = 1'b0;
      end
      PH_HDR:  raw = HDR_BYTE;
      PH_CODE: raw = {5'd0, item_r.size_code};
      PH_PHI:  raw = item_r.port_address[15:8];
      PH_PLO:  raw = item_r.port_address[7:0];
      PH_DATA: raw = item_r.payload_byte;
      PH_CRCL: begin
        raw       = ~crc_r[7:0];
        feeds_crc = 1'b0;
      end
      PH_CRCH: begin
        raw       = ~crc_r[15:8];
        feeds_crc = 1'b0;
      end
      PH_END: begin
        raw       = FLAG_BYTE;
        escapable = 1'b0;
        feeds_crc = 1'b0;
      end
      default: begin
        raw       = FLAG_BYTE;
        escapable = 1'b0;
        feeds_crc = 1'b0;
      end
    endcase
  end

  assign need_esc = escapable && (raw == FLAG_BYTE || raw == ESC_BYTE);
  assign complete = esc_pend_r || !need_esc;

  // Step order within one item.
  always_comb begin
    next_phase = PH_DATA;
    finishing  = 1'b0;
    unique case (phase_r)
      PH_FLAG: next_phase = PH_HDR;
      PH_HDR:  next_phase = PH_CODE;
      PH_CODE: next_phase = PH_PHI;
      PH_PHI:  next_phase = PH_PLO;
      PH_PLO:  next_phase = PH_DATA;
      PH_DATA: begin
        next_phase = PH_CRCL;
        finishing  = !item_r.last;
      end
      PH_CRCL: next_phase = PH_CRCH;
      PH_CRCH: next_phase = PH_END;
      PH_END:  finishing = 1'b1;
      default: finishing = 1'b1;
    endcase
  end

  assign pop = q_valid && (!busy_r || (emit && complete && finishing));

  // Sequencer, CRC and output register.
  always_comb begin
    item_nxt      = item_r;
    busy_nxt      = busy_r;
    phase_nxt     = phase_r;
    esc_pend_nxt  = esc_pend_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_end_nxt   = out_end_r;

    if (adv) begin
      out_valid_nxt = emit;
    end

    if (emit) begin
      if (esc_pend_r) begin
        out_byte_nxt = (raw == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
      end else if (need_esc) begin
        out_byte_nxt = ESC_BYTE;
      end else begin
        out_byte_nxt = raw;
      end
      out_last_nxt = complete && finishing;
      out_end_nxt  = (phase_r == PH_END);
      esc_pend_nxt = !esc_pend_r && need_esc;

      // The CRC restarts at the opening flag and takes each raw byte once.
      if (phase_r == PH_FLAG) begin
        crc_nxt = CRC_INIT;
      end else if (feeds_crc && !esc_pend_r) begin
        crc_nxt = crc_feed(crc_r, raw);
      end

      if (complete) begin
        if (finishing) begin
          busy_nxt = 1'b0;
        end else begin
          phase_nxt = next_phase;
        end
      end
    end

    if (pop) begin
      item_nxt     = q_item;
      busy_nxt     = 1'b1;
      phase_nxt    = q_item.open ? PH_FLAG : PH_DATA;
      esc_pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_FLAG;
      esc_pend_r  <= 1'b0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      phase_r     <= phase_nxt;
      esc_pend_r  <= esc_pend_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.line_byte = out_byte_r;
  assign out_ch.run_last  = out_last_r;
  assign out_ch.frame_end = out_end_r;

  `CRCFB_ASSERT(a_esc_only_busy, (esc_pend_r |-> busy_r), "escape pending while idle")
  `CRCFB_ASSERT(a_esc_second_half, (busy_r && esc_pend_r && adv |=> (out_byte_r == ESC_FLAG || out_byte_r == ESC_ESC)), "bad escape code")
  `CRCFB_ASSERT(a_end_is_last, (out_valid_r && out_end_r |-> out_last_r && out_byte_r == FLAG_BYTE), "closing flag not last")

endmodule
